@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIDA_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/sida_pkg.sv @@
// ---------------------------------------------------------------------------
// sida_pkg
// types and constants of the signed integer to decimal text converter
// ---------------------------------------------------------------------------
`default_nettype none

package sida_pkg;

   localparam int VALUE_W      = 32;
   localparam int CHAR_W       = 8;
   localparam int DIGIT_W      = 4;
   localparam int DABBLE_STEPS = 8;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'd45;
   localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      channel_closed;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/sida_front.sv @@
// ---------------------------------------------------------------------------
// sida_front
// input stage: width trim or zero extension, sign split and magnitude, closed items dropped
// ---------------------------------------------------------------------------
`default_nettype none

module sida_front #(
   parameter int VALUE_BITS = 32,
   parameter int MAG_W      = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_stall,
   input  wire sida_pkg::req_type     in_item,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output logic                       out_neg,
   output logic [MAG_W-1:0]           out_mag
);

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  neg_ff;
   logic [MAG_W-1:0]      mag_ff;

   generate
      if (VALUE_BITS <= sida_pkg::VALUE_W) begin : g_trim
         assign raw = in_item.value[VALUE_BITS-1:0];
      end else begin : g_extend
         assign raw = {{(VALUE_BITS - sida_pkg::VALUE_W){1'b0}}, in_item.value};
      end
   endgenerate

   assign neg      = raw[VALUE_BITS-1];
   assign mag      = neg ? VALUE_BITS'(~raw + 1'b1) : raw;
   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_valid && !in_item.channel_closed;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && valid_in) begin
         neg_ff <= neg;
         mag_ff <= MAG_W'(mag);
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;

endmodule

`default_nettype wire

@@ design/sida_dabble.sv @@
// ---------------------------------------------------------------------------
// sida_dabble
// one pipeline stage of shift-and-add-three binary to bcd conversion
// ---------------------------------------------------------------------------
`default_nettype none

module sida_dabble #(
   parameter int MAG_W = 32,
   parameter int BCD_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire logic              in_neg,
   input  wire logic [MAG_W-1:0]  in_mag,
   input  wire logic [BCD_W-1:0]  in_bcd,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output logic                   out_neg,
   output logic [MAG_W-1:0]       out_mag,
   output logic [BCD_W-1:0]       out_bcd
);

   localparam int NUM_DIGITS = BCD_W / sida_pkg::DIGIT_W;

   logic [MAG_W-1:0] mag_in;
   logic [BCD_W-1:0] bcd_in;
   logic             valid_ff;
   logic             neg_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [BCD_W-1:0] bcd_ff;

   always_comb begin
      logic [MAG_W-1:0] mag_v;
      logic [BCD_W-1:0] bcd_v;
      mag_v = in_mag;
      bcd_v = in_bcd;
      for (int s = 0; s < sida_pkg::DABBLE_STEPS; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_v[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= sida_pkg::BCD_ADJ_LIMIT) begin
               bcd_v[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                  bcd_v[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + sida_pkg::BCD_ADJ;
            end
         end
         bcd_v = {bcd_v[BCD_W-2:0], mag_v[MAG_W-1]};
         mag_v = {mag_v[MAG_W-2:0], 1'b0};
      end
      mag_in = mag_v;
      bcd_in = bcd_v;
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         neg_ff <= in_neg;
         mag_ff <= mag_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;
   assign out_bcd   = bcd_ff;

endmodule

`default_nettype wire

@@ design/sida_emit.sv @@
// ---------------------------------------------------------------------------
// sida_emit
// character serialiser: sign, then digits from the most significant one
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sida_emit #(
   parameter int BCD_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire logic              in_neg,
   input  wire logic [BCD_W-1:0]  in_bcd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sida_pkg::rsp_type      rsp_item
);

   localparam int NUM_DIGITS = BCD_W / sida_pkg::DIGIT_W;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int IDX_MAX    = NUM_DIGITS - 1;

   logic [IDX_W-1:0]            msd;
   logic                        slot_free;
   logic                        emit;
   logic                        final_char;
   logic                        load;
   logic                        active_ff;
   logic                        minus_ff;
   logic                        rsp_valid_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [sida_pkg::DIGIT_W-1:0] digit_ff [NUM_DIGITS];
   sida_pkg::rsp_type           rsp_ff;

   // highest non-zero digit, zero when the value is zero
   always_comb begin
      msd = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (in_bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0) begin
            msd = IDX_W'(d);
         end
      end
   end

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign emit       = active_ff && slot_free;
   assign final_char = !minus_ff && (idx_ff == '0);
   assign in_stall   = active_ff && !(emit && final_char);
   assign load       = in_valid && !in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         minus_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (slot_free) begin
            rsp_valid_ff <= emit;
         end
         // a new item may follow the final character of the previous one
         if (load) begin
            active_ff <= 1'b1;
            minus_ff  <= in_neg;
         end else if (emit) begin
            if (minus_ff) begin
               minus_ff <= 1'b0;
            end else if (idx_ff == '0) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (minus_ff) begin
            rsp_ff.character <= sida_pkg::CHAR_MINUS;
         end else begin
            rsp_ff.character <= sida_pkg::CHAR_ZERO
                              + {{(sida_pkg::CHAR_W - sida_pkg::DIGIT_W){1'b0}},
                                 digit_ff[idx_ff]};
         end
         rsp_ff.last <= final_char;
      end
      if (load) begin
         idx_ff <= msd;
         for (int d = 0; d < NUM_DIGITS; d++) begin
            digit_ff[d] <= in_bcd[d*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
         end
      end else if (emit && !minus_ff) begin
         idx_ff <= idx_ff - IDX_W'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SIDA_ASSERT_IMPLY(a_run_pending, rsp_valid_ff && !rsp_ff.last, active_ff, "run ended early")
   `SIDA_ASSERT_IMPLY(a_minus_in_run, minus_ff, active_ff, "sign pending outside a run")
   `SIDA_ASSERT_IMPLY(a_idx_range, active_ff, idx_ff <= IDX_W'(IDX_MAX), "digit index out of range")
   `SIDA_ASSERT_NEXT(a_load_starts, load, active_ff, "load did not start a run")

endmodule

`default_nettype wire

@@ design/signed_int_to_decimal_ascii.sv @@
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed integer in, decimal text out one character per item, sign first
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  value, channel_closed
// rsp_      out        rsp_valid/rsp_stall  character, last
//
// an item passes the front register, every bcd stage register and the serialiser before its first character is valid
// one character per cycle while rsp_stall is low; an item holds the serialiser until its last character is sent
// closed items are taken and produce nothing
// reset is synchronous and clears only the valid and run-control flags
// a stall on rsp_ backs up through the bcd pipeline stage by stage
// ---------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sida_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sida_pkg::rsp_type      rsp_payload
);

   localparam int NSTAGES    = (VALUE_BITS + sida_pkg::DABBLE_STEPS - 1) / sida_pkg::DABBLE_STEPS;
   localparam int MAG_W      = NSTAGES * sida_pkg::DABBLE_STEPS;
   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W      = NUM_DIGITS * sida_pkg::DIGIT_W;

   logic             pipe_valid [NSTAGES+1];
   logic             pipe_stall [NSTAGES+1];
   logic             pipe_neg   [NSTAGES+1];
   logic [MAG_W-1:0] pipe_mag   [NSTAGES+1];
   logic [BCD_W-1:0] pipe_bcd   [NSTAGES+1];

   sida_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAG_W      (MAG_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_payload),
      .out_valid (pipe_valid[0]),
      .out_stall (pipe_stall[0]),
      .out_neg   (pipe_neg[0]),
      .out_mag   (pipe_mag[0])
   );

   assign pipe_bcd[0] = '0;

   generate
      for (genvar k = 0; k < NSTAGES; k++) begin : g_stage
         sida_dabble #(
            .MAG_W (MAG_W),
            .BCD_W (BCD_W)
         ) u_dabble (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (pipe_valid[k]),
            .in_stall  (pipe_stall[k]),
            .in_neg    (pipe_neg[k]),
            .in_mag    (pipe_mag[k]),
            .in_bcd    (pipe_bcd[k]),
            .out_valid (pipe_valid[k+1]),
            .out_stall (pipe_stall[k+1]),
            .out_neg   (pipe_neg[k+1]),
            .out_mag   (pipe_mag[k+1]),
            .out_bcd   (pipe_bcd[k+1])
         );
      end
   endgenerate

   sida_emit #(
      .BCD_W (BCD_W)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_valid[NSTAGES]),
      .in_stall  (pipe_stall[NSTAGES]),
      .in_neg    (pipe_neg[NSTAGES]),
      .in_bcd    (pipe_bcd[NSTAGES]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_payload)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// drives signed integers into the converter and checks the decimal text that
// comes back, character by character, against texts typed into a short
// stimulus table and, for every other item, against a local decimal predictor.
// both channels idle and stall at random; the receiver holds off once for a
// long stretch so that the converter fills up and stalls its input
// ---------------------------------------------------------------------------
`default_nettype none

module tb_signed_int_to_decimal_ascii;

   localparam int DIRECTED_ROWS  = 21;
   localparam int RANDOM_ITEMS   = 290;
   localparam int DECIMAL_BASE   = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int CALM_FIRST     = 120;
   localparam int CALM_LAST      = 180;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   sida_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   sida_pkg::rsp_type rsp_payload;

   sida_pkg::rsp_type pending_chars [$];
   int                failures       = 0;
   int                items_accepted = 0;
   int                idle_cycles    = 0;
   bit                holdoff_done   = 1'b0;

   sida_pkg::req_type directed_items [DIRECTED_ROWS] = '{
      '{32'sd0, 1'b0},
      '{32'sd1, 1'b0},
      '{-32'sd1, 1'b0},
      '{32'sd9, 1'b0},
      '{32'sd10, 1'b0},
      '{-32'sd10, 1'b0},
      '{32'sh7fff_ffff, 1'b0},
      '{32'sh8000_0000, 1'b0},
      '{32'sh8000_0001, 1'b0},
      '{32'sd99, 1'b0},
      '{32'sd100, 1'b0},
      '{-32'sd99999, 1'b0},
      '{32'sd1000000000, 1'b0},
      '{32'sd999999999, 1'b0},
      '{-32'sd1000000000, 1'b0},
      '{32'sd12345, 1'b1},
      '{32'sh8000_0000, 1'b1},
      '{32'sd0, 1'b1},
      '{32'sh5555_5555, 1'b0},
      '{32'shaaaa_aaaa, 1'b0},
      '{-32'sd8, 1'b0}
   };

   // empty text: expected characters come from the predictor
   string directed_text [DIRECTED_ROWS] = '{
      "0", "1", "-1", "9", "10", "-10", "2147483647", "-2147483648",
      "-2147483647", "", "", "", "", "", "", "", "", "", "", "", ""
   };

   signed_int_to_decimal_ascii uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_decimal_text(input sida_pkg::req_type item);
      logic [sida_pkg::VALUE_W-1:0] magnitude;
      logic [sida_pkg::VALUE_W-1:0] remainder;
      logic [sida_pkg::CHAR_W-1:0]  digits [$];
      sida_pkg::rsp_type            ch;
      bit                           negative;
      if (item.channel_closed)
         return;
      magnitude = item.value;
      negative  = magnitude[sida_pkg::VALUE_W-1];
      if (negative)
         magnitude = ~magnitude + 1'b1;
      do begin
         remainder = magnitude % DECIMAL_BASE;
         digits.push_front(sida_pkg::CHAR_ZERO + remainder[sida_pkg::CHAR_W-1:0]);
         magnitude = magnitude / DECIMAL_BASE;
      end while (magnitude != 0);
      if (negative) begin
         ch.character = sida_pkg::CHAR_MINUS;
         ch.last      = 1'b0;
         pending_chars.push_back(ch);
      end
      foreach (digits[i]) begin
         ch.character = digits[i];
         ch.last      = (i == digits.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic void expect_typed_text(input string text);
      sida_pkg::rsp_type ch;
      for (int i = 0; i < text.len(); i++) begin
         ch.character = text[i];
         ch.last      = (i == text.len() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   // mostly values of a random digit count, some full width, some closed
   function automatic sida_pkg::req_type random_item();
      sida_pkg::req_type            item;
      longint                       span;
      longint                       drawn;
      int                           pick;
      logic [sida_pkg::VALUE_W-1:0] magnitude;
      pick = $urandom_range(99);
      item.channel_closed = (pick < 8);
      span = 1;
      repeat ($urandom_range(10, 1)) span = span * DECIMAL_BASE;
      if (pick < 30)
         drawn = longint'($urandom);
      else if (pick < 40)
         drawn = span - $urandom_range(1);
      else
         drawn = longint'($urandom) % span;
      magnitude  = drawn[sida_pkg::VALUE_W-1:0];
      item.value = $urandom_range(1) ? -magnitude : magnitude;
      return item;
   endfunction

   task automatic flag_char(input string what, input sida_pkg::rsp_type want,
                            input sida_pkg::rsp_type got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t %s: expected char %0d last %0b, got char %0d last %0b",
                  $realtime, what, want.character, want.last, got.character, got.last);
   endtask

   task automatic offer_item(input sida_pkg::req_type item, input string text);
      if ((items_accepted < CALM_FIRST || items_accepted >= CALM_LAST)
          && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_accepted++;
      if (text.len() != 0)
         expect_typed_text(text);
      else
         predict_decimal_text(item);
   endtask

   // sender
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < DIRECTED_ROWS; r++)
         offer_item(directed_items[r], directed_text[r]);
      for (int n = 0; n < RANDOM_ITEMS; n++)
         offer_item(random_item(), "");
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // receiver stalls, one long hold-off, and a calm stretch
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!holdoff_done && items_accepted >= 60) begin
            holdoff_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         if (items_accepted >= CALM_FIRST && items_accepted < CALM_LAST)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 35);
      end
   end

   // result checker
   always @(posedge clock) begin
      sida_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            flag_char("unexpected item", '0, rsp_payload);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_payload.character !== want.character || rsp_payload.last !== want.last)
               flag_char("mismatch", want, rsp_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
